FILE: sv/cylinder_closest_point_unit_assert.svh
// assertion macros for the cylinder closest point unit
`ifndef CYLINDER_CLOSEST_POINT_UNIT_ASSERT_SVH
`define CYLINDER_CLOSEST_POINT_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CCP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ccp assertion failed");

// next-cycle implication, disabled during reset
`define CCP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ccp assertion failed");

`endif

FILE: sv/ccp_pkg.sv
// shared types, widths and helpers for the cylinder closest point unit
`default_nettype none
package ccp_pkg;

  localparam int COORD_WIDTH    = 32;
  localparam int REG_WIDTH      = COORD_WIDTH - 1;
  localparam int SQ_WIDTH       = 2 * COORD_WIDTH;
  localparam int SQRT_STAGES    = COORD_WIDTH;
  localparam int SQRT_REM_WIDTH = COORD_WIDTH + 2;
  localparam int NUM_WIDTH      = REG_WIDTH + COORD_WIDTH;
  localparam int DIV_STAGES     = REG_WIDTH;
  localparam int ADDR_WIDTH     = 3;
  localparam int DATA_WIDTH     = 32;

  localparam logic REG_RADIUS      = 1'b0;
  localparam logic REG_HALF_LENGTH = 1'b1;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] probe_x;
    logic signed [COORD_WIDTH-1:0] probe_y;
    logic signed [COORD_WIDTH-1:0] probe_z;
  } probe_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] near_x;
    logic signed [COORD_WIDTH-1:0] near_y;
    logic signed [COORD_WIDTH-1:0] near_z;
  } near_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] near_x;
    logic signed [COORD_WIDTH-1:0] probe_y;
    logic signed [COORD_WIDTH-1:0] probe_z;
    logic                          proj;
    logic                          r_zero;
  } sel_t;

  function automatic logic [COORD_WIDTH-1:0] abs_mag(input logic signed [COORD_WIDTH-1:0] a);
    logic signed [COORD_WIDTH-1:0] n;
    n = -a;
    return a[COORD_WIDTH-1] ? COORD_WIDTH'(n) : COORD_WIDTH'(a);
  endfunction

endpackage
`default_nettype wire

FILE: sv/cylinder_closest_point_unit.sv
// Closest point on an x-axis cylinder: one probe request per cycle while the
// output is not stalled. Results pass through the 32-stage square root
// pipeline for the radial distance and the 31-stage divider for the radial
// projection; the whole pipeline holds while the output is stalled.
`default_nettype none
`include "cylinder_closest_point_unit_assert.svh"
module cylinder_closest_point_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [ccp_pkg::ADDR_WIDTH-1:0]   paddr,
  input  wire logic [ccp_pkg::DATA_WIDTH-1:0]   pwdata,
  output logic [ccp_pkg::DATA_WIDTH-1:0]        prdata,
  output logic                                  pready,
  input  wire logic                             probe_valid,
  output logic                                  probe_ready,
  input  wire ccp_pkg::probe_t                  probe,
  output logic                                  near_valid,
  input  wire logic                             near_ready,
  output ccp_pkg::near_t                        near
);
  import ccp_pkg::*;

  logic [REG_WIDTH-1:0] radius;
  logic [REG_WIDTH-1:0] half_length;
  logic                 en;

  assign pready = 1'b1;
  assign en     = !near_valid || near_ready;
  assign probe_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius      <= '0;
      half_length <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_RADIUS:      radius      <= pwdata[REG_WIDTH-1:0];
        REG_HALF_LENGTH: half_length <= pwdata[REG_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_RADIUS:      prdata = {{(DATA_WIDTH-REG_WIDTH){1'b0}}, radius};
      REG_HALF_LENGTH: prdata = {{(DATA_WIDTH-REG_WIDTH){1'b0}}, half_length};
      default:         prdata = '0;
    endcase
  end

  // input, squares, sum
  logic                v0, v1, v2;
  probe_t              p0, p1, p2;
  logic [SQ_WIDTH-1:0] sqy1, sqz1, sum2;
  logic [COORD_WIDTH-1:0] ay0, az0;

  assign ay0 = abs_mag(p0.probe_y);
  assign az0 = abs_mag(p0.probe_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v0 <= probe_valid;
      v1 <= v0;
      v2 <= v1;
    end
    if (en) begin
      p0   <= probe;
      p1   <= p0;
      p2   <= p1;
      sqy1 <= {{COORD_WIDTH{1'b0}}, ay0} * {{COORD_WIDTH{1'b0}}, ay0};
      sqz1 <= {{COORD_WIDTH{1'b0}}, az0} * {{COORD_WIDTH{1'b0}}, az0};
      sum2 <= sqy1 + sqz1;
    end
  end

  // radial distance
  logic                   vq;
  logic [COORD_WIDTH-1:0] rq;
  probe_t                 side_sq [SQRT_STAGES];

  ccp_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v2),
    .radicand  (sum2),
    .out_valid (vq),
    .root      (rq)
  );

  for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_sq_side
    always_ff @(posedge clk) begin
      if (en) begin
        side_sq[i] <= (i == 0) ? p2 : side_sq[(i == 0) ? 0 : i-1];
      end
    end
  end

  // region select and projection numerators
  probe_t                   ps;
  logic [COORD_WIDTH-1:0]   ax;
  logic signed [COORD_WIDTH+1:0] dh, dr;
  logic signed [COORD_WIDTH-1:0] hl_pos, hl_neg;
  logic                     in_body, to_cap;
  sel_t                     sel_c;

  always_comb begin
    ps      = side_sq[SQRT_STAGES-1];
    ax      = abs_mag(ps.probe_x);
    dh      = signed'({2'b00, ax}) - signed'({3'b000, half_length});
    dr      = signed'({2'b00, rq}) - signed'({3'b000, radius});
    hl_pos  = signed'({1'b0, half_length});
    hl_neg  = -hl_pos;
    in_body = (dr <= 0) && (dh <= 0);
    to_cap  = (dh > 0) || (in_body && (dr < dh));
    sel_c.near_x  = to_cap ? (ps.probe_x[COORD_WIDTH-1] ? hl_neg : hl_pos) : ps.probe_x;
    sel_c.probe_y = ps.probe_y;
    sel_c.probe_z = ps.probe_z;
    sel_c.proj    = (dr > 0) || (in_body && (dr >= dh));
    sel_c.r_zero  = (rq == '0);
  end

  logic                   v3;
  sel_t                   side3;
  logic [NUM_WIDTH-1:0]   numy3, numz3;
  logic [COORD_WIDTH-1:0] den3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= vq;
    end
    if (en) begin
      side3 <= sel_c;
      numy3 <= {{COORD_WIDTH{1'b0}}, radius} * {{REG_WIDTH{1'b0}}, abs_mag(ps.probe_y)};
      numz3 <= {{COORD_WIDTH{1'b0}}, radius} * {{REG_WIDTH{1'b0}}, abs_mag(ps.probe_z)};
      den3  <= (rq == '0) ? COORD_WIDTH'(1) : rq;
    end
  end

  // projection divide
  logic                 vd;
  logic [REG_WIDTH-1:0] quot_y, quot_z;
  sel_t                 side_dv [DIV_STAGES];

  ccp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .num_y     (numy3),
    .num_z     (numz3),
    .den       (den3),
    .out_valid (vd),
    .quot_y    (quot_y),
    .quot_z    (quot_z)
  );

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_dv_side
    always_ff @(posedge clk) begin
      if (en) begin
        side_dv[i] <= (i == 0) ? side3 : side_dv[(i == 0) ? 0 : i-1];
      end
    end
  end

  // output register
  sel_t                          so;
  logic signed [COORD_WIDTH-1:0] qy, qz, py, pz, rad_s;
  near_t                         near_c;

  always_comb begin
    so    = side_dv[DIV_STAGES-1];
    qy    = signed'({1'b0, quot_y});
    qz    = signed'({1'b0, quot_z});
    rad_s = signed'({1'b0, radius});
    py    = so.r_zero ? rad_s : (so.probe_y[COORD_WIDTH-1] ? -qy : qy);
    pz    = so.r_zero ? '0 : (so.probe_z[COORD_WIDTH-1] ? -qz : qz);
    near_c.near_x = so.near_x;
    near_c.near_y = so.proj ? py : so.probe_y;
    near_c.near_z = so.proj ? pz : so.probe_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      near_valid <= 1'b0;
    end else if (en) begin
      near_valid <= vd;
    end
    if (en) begin
      near <= near_c;
    end
  end

  `CCP_ASSERT_NOW(a_axis_root, v3 && side3.r_zero, side3.probe_y == 0 && side3.probe_z == 0)
  `CCP_ASSERT_NOW(a_proj_bound, vd && so.proj && !so.r_zero, quot_y <= radius && quot_z <= radius)
  `CCP_ASSERT_NEXT(a_stall_hold, !en, $stable(vd) && $stable(quot_y) && $stable(v3))

endmodule
`default_nettype wire

FILE: sv/ccp_sqrt.sv
// pipelined integer square root, one result bit per stage
`default_nettype none
module ccp_sqrt (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic [ccp_pkg::SQ_WIDTH-1:0]  radicand,
  output logic                               out_valid,
  output logic [ccp_pkg::COORD_WIDTH-1:0]    root
);
  import ccp_pkg::*;

  logic                      vld  [SQRT_STAGES];
  logic [SQRT_REM_WIDTH-1:0] rem  [SQRT_STAGES];
  logic [COORD_WIDTH-1:0]    rt   [SQRT_STAGES];
  logic [SQ_WIDTH-1:0]       rest [SQRT_STAGES];

  for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
    logic                        vld_p;
    logic [SQRT_REM_WIDTH-1:0]   rem_p;
    logic [COORD_WIDTH-1:0]      rt_p;
    logic [SQ_WIDTH-1:0]         rest_p;
    logic [SQRT_REM_WIDTH+1:0]   cur;
    logic [SQRT_REM_WIDTH+1:0]   trial;
    logic [SQRT_REM_WIDTH+1:0]   diff;
    logic                        ge;

    if (i == 0) begin : g_first
      assign vld_p  = in_valid;
      assign rem_p  = '0;
      assign rt_p   = '0;
      assign rest_p = radicand;
    end else begin : g_next
      assign vld_p  = vld[i-1];
      assign rem_p  = rem[i-1];
      assign rt_p   = rt[i-1];
      assign rest_p = rest[i-1];
    end

    always_comb begin
      cur   = {rem_p, rest_p[SQ_WIDTH-1 -: 2]};
      trial = {{(SQRT_REM_WIDTH-COORD_WIDTH){1'b0}}, rt_p, 2'b01};
      diff  = cur - trial;
      ge    = (cur >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= vld_p;
      end
      if (en) begin
        rem[i]  <= ge ? diff[SQRT_REM_WIDTH-1:0] : cur[SQRT_REM_WIDTH-1:0];
        rt[i]   <= {rt_p[COORD_WIDTH-2:0], ge};
        rest[i] <= {rest_p[SQ_WIDTH-3:0], 2'b00};
      end
    end
  end

  assign out_valid = vld[SQRT_STAGES-1];
  assign root      = rt[SQRT_STAGES-1];

endmodule
`default_nettype wire

FILE: sv/ccp_div.sv
// pipelined two-lane restoring divider, one quotient bit per stage
`default_nettype none
module ccp_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic [ccp_pkg::NUM_WIDTH-1:0] num_y,
  input  wire logic [ccp_pkg::NUM_WIDTH-1:0] num_z,
  input  wire logic [ccp_pkg::COORD_WIDTH-1:0] den,
  output logic                               out_valid,
  output logic [ccp_pkg::REG_WIDTH-1:0]      quot_y,
  output logic [ccp_pkg::REG_WIDTH-1:0]      quot_z
);
  import ccp_pkg::*;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] rem;
    logic [DIV_STAGES-1:0]  rest;
    logic [REG_WIDTH-1:0]   quot;
  } lane_t;

  logic                   vld [DIV_STAGES];
  logic [COORD_WIDTH-1:0] dv  [DIV_STAGES];
  lane_t                  ly  [DIV_STAGES];
  lane_t                  lz  [DIV_STAGES];

  function automatic lane_t lane_step(input lane_t p, input logic [COORD_WIDTH-1:0] d);
    logic [COORD_WIDTH:0] cur;
    logic [COORD_WIDTH:0] diff;
    logic                 ge;
    lane_t                n;
    cur    = {p.rem, p.rest[DIV_STAGES-1]};
    diff   = cur - {1'b0, d};
    ge     = (cur >= {1'b0, d});
    n.rem  = ge ? diff[COORD_WIDTH-1:0] : cur[COORD_WIDTH-1:0];
    n.rest = {p.rest[DIV_STAGES-2:0], 1'b0};
    n.quot = {p.quot[REG_WIDTH-2:0], ge};
    return n;
  endfunction

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    logic                   vld_p;
    logic [COORD_WIDTH-1:0] dv_p;
    lane_t                  ly_p;
    lane_t                  lz_p;

    if (i == 0) begin : g_first
      assign vld_p = in_valid;
      assign dv_p  = den;
      assign ly_p  = '{rem: num_y[NUM_WIDTH-1 -: COORD_WIDTH],
                       rest: num_y[DIV_STAGES-1:0], quot: '0};
      assign lz_p  = '{rem: num_z[NUM_WIDTH-1 -: COORD_WIDTH],
                       rest: num_z[DIV_STAGES-1:0], quot: '0};
    end else begin : g_next
      assign vld_p = vld[i-1];
      assign dv_p  = dv[i-1];
      assign ly_p  = ly[i-1];
      assign lz_p  = lz[i-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= vld_p;
      end
      if (en) begin
        dv[i] <= dv_p;
        ly[i] <= lane_step(ly_p, dv_p);
        lz[i] <= lane_step(lz_p, dv_p);
      end
    end
  end

  assign out_valid = vld[DIV_STAGES-1];
  assign quot_y    = ly[DIV_STAGES-1].quot;
  assign quot_z    = lz[DIV_STAGES-1].quot;

endmodule
`default_nettype wire

FILE: bench/testbench.sv
// testbench for the cylinder closest point unit: random and directed probes checked against a predictor
`default_nettype none
class near_point_board;
  ccp_pkg::near_t pending[$];
  int errors;
  int checked;
  logic [30:0] radius;
  logic [30:0] half_length;

  function new();
    errors = 0;
    checked = 0;
    radius = '0;
    half_length = '0;
  endfunction

  function logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function longint project(input longint c, input longint r);
    logic [63:0] m;
    logic [63:0] q;
    m = c < 0 ? -c : c;
    q = (64'(radius) * m) / 64'(r);
    return c < 0 ? -longint'(q) : longint'(q);
  endfunction

  function void note_probe(input ccp_pkg::probe_t p);
    longint x, y, z, hl, rad, r, ax, dh, dr, cl, py, pz, nx, ny, nz;
    logic [63:0] uy, uz;
    ccp_pkg::near_t n;
    x = longint'(p.probe_x);
    y = longint'(p.probe_y);
    z = longint'(p.probe_z);
    hl = longint'(half_length);
    rad = longint'(radius);
    uy = y < 0 ? -y : y;
    uz = z < 0 ? -z : z;
    r = longint'(int_sqrt(uy * uy + uz * uz));
    ax = x < 0 ? -x : x;
    dh = ax - hl;
    dr = r - rad;
    cl = x > hl ? hl : (x < -hl ? -hl : x);
    if (r > 0) begin
      py = project(y, r);
      pz = project(z, r);
    end else begin
      py = rad;
      pz = 0;
    end
    if (dr <= 0 && dh <= 0) begin
      if (dr >= dh) begin
        nx = x; ny = py; nz = pz;
      end else begin
        nx = x >= 0 ? hl : -hl; ny = y; nz = z;
      end
    end else if (dh > 0 && dr <= 0) begin
      nx = cl; ny = y; nz = z;
    end else if (dr > 0 && dh <= 0) begin
      nx = x; ny = py; nz = pz;
    end else begin
      nx = cl; ny = py; nz = pz;
    end
    n.near_x = nx[31:0];
    n.near_y = ny[31:0];
    n.near_z = nz[31:0];
    pending.push_back(n);
  endfunction

  function void check_near(input ccp_pkg::near_t got);
    ccp_pkg::near_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    checked++;
    if (got.near_x !== want.near_x) begin
      $display("%0t: near_x expected %h actual %h", $time, want.near_x, got.near_x);
      errors++;
    end
    if (got.near_y !== want.near_y) begin
      $display("%0t: near_y expected %h actual %h", $time, want.near_y, got.near_y);
      errors++;
    end
    if (got.near_z !== want.near_z) begin
      $display("%0t: near_z expected %h actual %h", $time, want.near_z, got.near_z);
      errors++;
    end
  endfunction
endclass

module testbench;
  import ccp_pkg::*;

  localparam int LATENCY = 68;
  localparam int WATCHDOG = 20000;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [ADDR_WIDTH-1:0] paddr;
  logic [DATA_WIDTH-1:0] pwdata;
  logic [DATA_WIDTH-1:0] prdata;
  logic pready;
  logic probe_valid, probe_ready;
  probe_t probe;
  logic near_valid, near_ready;
  near_t near;

  near_point_board board;
  int send_idle_pct;
  int recv_stall_pct;
  int idle_cycles;
  int sent;

  cylinder_closest_point_unit uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .probe_valid(probe_valid), .probe_ready(probe_ready), .probe(probe),
    .near_valid(near_valid), .near_ready(near_ready), .near(near)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side: random stall, check on accept
  always @(posedge clk) begin
    if (rst) begin
      near_ready <= 1'b0;
    end else begin
      if (near_valid && near_ready) board.check_near(near);
      near_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (probe_valid && probe_ready) || (near_valid && near_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("cylinder_closest_point_unit regression: fail");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic addr_sel, input logic [30:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_WIDTH'(addr_sel) << 2;
    pwdata <= {1'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr_sel == REG_RADIUS) board.radius = value;
    else board.half_length = value;
  endtask

  task automatic send_probe(input probe_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      probe_valid <= 1'b0;
      @(posedge clk);
    end
    probe_valid <= 1'b1;
    probe <= p;
    @(posedge clk);
    while (!probe_ready) @(posedge clk);
    board.note_probe(p);
    sent++;
  endtask

  task automatic drain();
    probe_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(input logic [30:0] scale);
    logic [31:0] v;
    case ($urandom_range(5))
      0: v = $urandom();
      1: v = {$urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff};
      2: v = 32'($urandom_range(3)) - 32'd1;
      default: begin
        v = (scale == 0) ? $urandom_range(65535) : 32'($urandom_range(2 * scale + 2));
        v = $urandom_range(1) ? -v : v;
      end
    endcase
    return v;
  endfunction

  task automatic random_phase(input int count, input int idle, input int stall,
                              input logic [30:0] rad, input logic [30:0] hl);
    probe_t p;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    write_reg(REG_RADIUS, rad);
    write_reg(REG_HALF_LENGTH, hl);
    for (int i = 0; i < count; i++) begin
      p.probe_x = rand_coord(hl);
      p.probe_y = rand_coord(rad);
      p.probe_z = rand_coord(rad);
      send_probe(p);
      if (i == count / 2 && idle == 0) drain();
    end
    drain();
  endtask

  initial begin
    probe_t p;
    logic [31:0] edges [6];
    board = new();
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    probe_valid = 1'b0; probe = '0;
    send_idle_pct = 0; recv_stall_pct = 0; sent = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed corners
    edges = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h0003_0000};
    write_reg(REG_RADIUS, 31'h0002_0000);
    write_reg(REG_HALF_LENGTH, 31'h0004_0000);
    for (int i = 0; i < 6; i++) begin
      p.probe_x = edges[i];
      p.probe_y = edges[(i + 2) % 6];
      p.probe_z = edges[(i + 4) % 6];
      send_probe(p);
    end
    p = '{32'h0, 32'h0, 32'h0};                   send_probe(p);
    p = '{32'h0003_8000, 32'h0000_1000, 32'h0};   send_probe(p);
    p = '{32'hfffc_8000, 32'h0000_1000, 32'h0};   send_probe(p);
    p = '{32'h0001_0000, 32'h0001_8000, 32'h0};   send_probe(p);
    p = '{32'h0008_0000, 32'h0001_0000, 32'h0};   send_probe(p);
    p = '{32'h0001_0000, 32'h0005_0000, 32'hfffd_0000}; send_probe(p);
    p = '{32'hfff0_0000, 32'h0005_0000, 32'h0005_0000}; send_probe(p);
    p = '{32'h0009_0000, 32'h0, 32'h0};           send_probe(p);
    drain();
    write_reg(REG_RADIUS, 31'h0);
    write_reg(REG_HALF_LENGTH, 31'h0);
    p = '{32'h0, 32'h0, 32'h0};                   send_probe(p);
    p = '{32'hffff_0000, 32'h0001_0000, 32'h0};   send_probe(p);
    drain();
    write_reg(REG_RADIUS, 31'h7fff_ffff);
    write_reg(REG_HALF_LENGTH, 31'h7fff_ffff);
    p = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}; send_probe(p);
    p = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h0};   send_probe(p);
    p = '{32'h0, 32'h0, 32'h0};                   send_probe(p);
    drain();

    random_phase(600, 0, 0, 31'h0005_0000, 31'h000a_0000);
    random_phase(450, 88, 0, 31'($urandom()), 31'($urandom()));
    random_phase(450, 0, 88, 31'($urandom_range(65535)), 31'h7fff_ffff);
    random_phase(450, 8, 8, 31'h7fff_ffff, 31'($urandom_range(65535)));

    $display("%0d probes sent, %0d results checked over several radius and length settings",
             sent, board.checked);
    $display("phases covered full rate, idle sender, stalled receiver and mixed gaps");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("cylinder_closest_point_unit regression: pass");
    end else begin
      $display("cylinder_closest_point_unit regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
